/* rtl/tlbpt_pkg.sv */
// Shared types and constants of the TLB page-table translator.
// Used by tlbpt_ctrl, tlbpt_datapath and tlb_page_table_translator; no dependencies.
package tlbpt_pkg;

    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 128;
    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_BYTES  = 256;

    localparam int VA_W     = 16;
    localparam int PA_W     = 15;
    localparam int PAGE_W   = $clog2(PAGE_COUNT);
    localparam int OFF_W    = $clog2(PAGE_BYTES);
    localparam int FRAME_W  = $clog2(FRAME_COUNT);
    localparam int FIU_W    = $clog2(FRAME_COUNT + 1);
    localparam int PIDX_W   = $clog2(PAGE_COUNT + 1);
    localparam int TLB_IX_W = $clog2(TLB_ENTRIES);
    localparam int TLB_CT_W = $clog2(TLB_ENTRIES + 1);
    localparam int STAMP_W  = 32;
    localparam int PMEM_W   = FRAME_W + STAMP_W;

    // Register indexes of the configuration port
    localparam logic CFG_TLB_POLICY   = 1'b0;
    localparam logic CFG_FRAME_POLICY = 1'b1;

    // Replacement policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_TABLE,
        ST_SCAN,
        ST_EVICT_RD,
        ST_EVICT,
        ST_MAP,
        ST_TFILL,
        ST_TSCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic look;
        logic table_chk;
        logic scan;
        logic evict_rd;
        logic evict;
        logic map;
        logic tfill;
        logic tscan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic tlb_hit;
        logic page_valid;
        logic frames_full;
        logic frame_policy;
        logic scan_done;
        logic tlb_scan_needed;
        logic tscan_done;
        logic out_free;
    } status_t;

endpackage

/* rtl/tlbpt_ctrl.sv */
// Sequencer of the TLB page-table translator: walks one word through
// lookup, fault handling and TLB fill. Depends on tlbpt_pkg.
module tlbpt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tlbpt_pkg::status_t status,
    output tlbpt_pkg::cmd_t    cmd
);

    tlbpt_pkg::state_t state_reg;
    tlbpt_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlbpt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the steps and drive the datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            tlbpt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = tlbpt_pkg::ST_LOOK;
                end
            end
            tlbpt_pkg::ST_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = status.tlb_hit ? tlbpt_pkg::ST_DONE : tlbpt_pkg::ST_TABLE;
            end
            tlbpt_pkg::ST_TABLE:
            begin
                cmd.table_chk = 1'b1;
                priority if (status.page_valid)
                    state_next = tlbpt_pkg::ST_TFILL;
                else if (!status.frames_full)
                    state_next = tlbpt_pkg::ST_MAP;
                else if (status.frame_policy == tlbpt_pkg::POLICY_FIFO)
                    state_next = tlbpt_pkg::ST_EVICT_RD;
                else
                    state_next = tlbpt_pkg::ST_SCAN;
            end
            tlbpt_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                    state_next = tlbpt_pkg::ST_EVICT_RD;
            end
            tlbpt_pkg::ST_EVICT_RD:
            begin
                cmd.evict_rd = 1'b1;
                state_next   = tlbpt_pkg::ST_EVICT;
            end
            tlbpt_pkg::ST_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = tlbpt_pkg::ST_MAP;
            end
            tlbpt_pkg::ST_MAP:
            begin
                cmd.map    = 1'b1;
                state_next = tlbpt_pkg::ST_TFILL;
            end
            tlbpt_pkg::ST_TFILL:
            begin
                cmd.tfill  = 1'b1;
                state_next = status.tlb_scan_needed ? tlbpt_pkg::ST_TSCAN
                                                    : tlbpt_pkg::ST_DONE;
            end
            tlbpt_pkg::ST_TSCAN:
            begin
                cmd.tscan = 1'b1;
                if (status.tscan_done)
                    state_next = tlbpt_pkg::ST_DONE;
            end
            tlbpt_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = tlbpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlbpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/tlbpt_datapath.sv */
// Datapath of the TLB page-table translator: TLB, page table memory,
// frame owner memory, replacement scans and the result register. Depends on tlbpt_pkg.
module tlbpt_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlbpt_pkg::cmd_t               cmd,
    output tlbpt_pkg::status_t            status,
    input  logic                          cfg_valid,
    input  logic                          cfg_index,
    input  logic                          cfg_data,
    input  logic [tlbpt_pkg::VA_W-1:0]    virtual_address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tlbpt_pkg::PA_W-1:0]    physical_address,
    output logic                          tlb_hit,
    output logic                          page_fault,
    output logic [tlbpt_pkg::FRAME_W-1:0] fill_frame,
    output logic                          evicted
);

    localparam int FW = tlbpt_pkg::FRAME_W;
    localparam int SW = tlbpt_pkg::STAMP_W;
    localparam int PW = tlbpt_pkg::PAGE_W;
    localparam int TE = tlbpt_pkg::TLB_ENTRIES;
    localparam int TLB_IX_W_LOC = tlbpt_pkg::TLB_IX_W;

    // Configuration
    logic tlb_policy_reg;
    logic frame_policy_reg;

    // Word under work
    logic [tlbpt_pkg::VA_W-1:0] va_reg;
    logic [FW-1:0]              frame_reg;
    logic                       hit_reg;
    logic                       fault_reg;
    logic                       ev_reg;
    logic [PW-1:0]              page;
    logic [tlbpt_pkg::OFF_W-1:0] offset;

    // Global counters
    logic [tlbpt_pkg::FIU_W-1:0] fiu_reg;
    logic [FW-1:0]               rr_reg;
    logic [SW-1:0]               clock_reg;

    // Page table
    logic [tlbpt_pkg::PAGE_COUNT-1:0] pvalid_reg;
    logic [tlbpt_pkg::PMEM_W-1:0]     page_mem [tlbpt_pkg::PAGE_COUNT];
    logic [tlbpt_pkg::PMEM_W-1:0]     pm_rdata_reg;
    logic [tlbpt_pkg::PMEM_W-1:0]     pm_wdata;
    logic                             pm_we;
    logic                             pm_re;
    logic [PW-1:0]                    pm_raddr;
    logic [FW-1:0]                    pm_wframe;
    logic [FW-1:0]                    rd_frame;
    logic [SW-1:0]                    rd_stamp;

    // Frame owner memory
    logic [PW-1:0] frame_page [tlbpt_pkg::FRAME_COUNT];
    logic [PW-1:0] fp_rdata_reg;

    // LRU frame scan
    logic [tlbpt_pkg::PIDX_W-1:0] pidx_reg;
    logic [PW-1:0]                idx_d_reg;
    logic                         rdv_reg;
    logic                         found_reg;
    logic [SW-1:0]                best_reg;
    logic [FW-1:0]                best_frame_reg;
    logic                         scan_done;

    // TLB
    logic [TE-1:0]                  tvalid_reg;
    logic [PW-1:0]                  tpage_reg  [TE];
    logic [FW-1:0]                  tframe_reg [TE];
    logic [SW-1:0]                  tstamp_reg [TE];
    logic [TLB_IX_W_LOC-1:0]        tptr_reg;
    logic [tlbpt_pkg::TLB_CT_W-1:0] tcount_reg;
    logic                           thit;
    logic [TLB_IX_W_LOC-1:0]        thit_idx;
    logic                           tany_inv;
    logic [TLB_IX_W_LOC-1:0]        tinv_idx;
    logic                           tscan_needed;
    logic                           tscan_done;
    logic [tlbpt_pkg::TLB_CT_W-1:0] tidx_reg;
    logic [SW-1:0]                  tbest_reg;
    logic [TLB_IX_W_LOC-1:0]        tbest_slot_reg;
    logic                           twe;
    logic [TLB_IX_W_LOC-1:0]        twslot;

    assign page     = va_reg[tlbpt_pkg::OFF_W +: PW];
    assign offset   = va_reg[tlbpt_pkg::OFF_W-1:0];
    assign rd_frame = pm_rdata_reg[SW +: FW];
    assign rd_stamp = pm_rdata_reg[SW-1:0];

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_policy_reg   <= tlbpt_pkg::POLICY_FIFO;
            frame_policy_reg <= tlbpt_pkg::POLICY_FIFO;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tlbpt_pkg::CFG_TLB_POLICY:   tlb_policy_reg   <= cfg_data;
                tlbpt_pkg::CFG_FRAME_POLICY: frame_policy_reg <= cfg_data;
                default:                     tlb_policy_reg   <= tlb_policy_reg;
            endcase
        end
    end

    // Look the page up in the TLB, lowest matching entry first
    always_comb
    begin
        thit     = 1'b0;
        thit_idx = '0;
        tany_inv = 1'b0;
        tinv_idx = '0;
        for (int i = TE - 1; i >= 0; i--)
        begin
            if (tvalid_reg[i] && tpage_reg[i] == page)
            begin
                thit     = 1'b1;
                thit_idx = TLB_IX_W_LOC'(i);
            end
            if (!tvalid_reg[i])
            begin
                tany_inv = 1'b1;
                tinv_idx = TLB_IX_W_LOC'(i);
            end
        end
    end

    assign tscan_needed = (tlb_policy_reg == tlbpt_pkg::POLICY_LRU)
                          && (tcount_reg == tlbpt_pkg::TLB_CT_W'(TE)) && !tany_inv;
    assign tscan_done   = (tidx_reg == tlbpt_pkg::TLB_CT_W'(TE));
    assign scan_done    = pidx_reg[tlbpt_pkg::PIDX_W-1] && !rdv_reg;

    // Page table write and read port
    always_comb
    begin
        pm_we     = 1'b0;
        pm_wframe = frame_reg;
        if (cmd.look && thit)
        begin
            pm_we     = 1'b1;
            pm_wframe = tframe_reg[thit_idx];
        end
        else if (cmd.table_chk && pvalid_reg[page])
        begin
            pm_we     = 1'b1;
            pm_wframe = rd_frame;
        end
        else if (cmd.map)
        begin
            pm_we = 1'b1;
        end
        pm_wdata = {pm_wframe, clock_reg};
        pm_re    = cmd.look || (cmd.scan && !pidx_reg[tlbpt_pkg::PIDX_W-1]);
        pm_raddr = cmd.look ? page : pidx_reg[PW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (pm_we)
            page_mem[page] <= pm_wdata;
        if (pm_re)
            pm_rdata_reg <= page_mem[pm_raddr];
    end

    // Frame owner memory: which page holds each frame
    always_ff @(posedge clk)
    begin
        if (cmd.map)
            frame_page[frame_reg] <= page;
        if (cmd.evict_rd)
            fp_rdata_reg <= frame_page[frame_reg];
    end

    // Hold the word payload and the frame under work
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            va_reg <= virtual_address;
        if (cmd.look && thit)
            frame_reg <= tframe_reg[thit_idx];
        else if (cmd.table_chk)
        begin
            priority if (pvalid_reg[page])
                frame_reg <= rd_frame;
            else if (fiu_reg != tlbpt_pkg::FIU_W'(tlbpt_pkg::FRAME_COUNT))
                frame_reg <= fiu_reg[FW-1:0];
            else if (frame_policy_reg == tlbpt_pkg::POLICY_FIFO)
                frame_reg <= rr_reg;
            else
                frame_reg <= frame_reg;
        end
        else if (cmd.scan && scan_done)
            frame_reg <= found_reg ? best_frame_reg : '0;
    end

    // Track flags, counters and page valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg    <= 1'b0;
            fault_reg  <= 1'b0;
            ev_reg     <= 1'b0;
            fiu_reg    <= '0;
            rr_reg     <= '0;
            clock_reg  <= '0;
            pvalid_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                hit_reg   <= 1'b0;
                fault_reg <= 1'b0;
                ev_reg    <= 1'b0;
            end
            if (cmd.look)
                hit_reg <= thit;
            if (cmd.table_chk && !pvalid_reg[page])
            begin
                priority if (fiu_reg != tlbpt_pkg::FIU_W'(tlbpt_pkg::FRAME_COUNT))
                    fiu_reg <= fiu_reg + 1'b1;
                else if (frame_policy_reg == tlbpt_pkg::POLICY_FIFO)
                    rr_reg <= rr_reg + 1'b1;
                else
                    rr_reg <= rr_reg;
            end
            if (cmd.evict)
            begin
                pvalid_reg[fp_rdata_reg] <= 1'b0;
                ev_reg                   <= 1'b1;
            end
            if (cmd.map)
            begin
                pvalid_reg[page] <= 1'b1;
                fault_reg        <= 1'b1;
            end
            if (cmd.finish)
                clock_reg <= clock_reg + 1'b1;
        end
    end

    // Sweep page stamps for the least recently used frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pidx_reg  <= '0;
            rdv_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (cmd.table_chk)
        begin
            pidx_reg  <= '0;
            rdv_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            rdv_reg <= !pidx_reg[tlbpt_pkg::PIDX_W-1];
            if (!pidx_reg[tlbpt_pkg::PIDX_W-1])
                pidx_reg <= pidx_reg + 1'b1;
            if (rdv_reg && pvalid_reg[idx_d_reg] && (!found_reg || rd_stamp < best_reg))
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            idx_d_reg <= pidx_reg[PW-1:0];
            if (rdv_reg && pvalid_reg[idx_d_reg] && (!found_reg || rd_stamp < best_reg))
            begin
                best_reg       <= rd_stamp;
                best_frame_reg <= rd_frame;
            end
        end
    end

    // Pick the TLB slot to write
    always_comb
    begin
        twe    = 1'b0;
        twslot = tbest_slot_reg;
        if (cmd.tfill && !tscan_needed)
        begin
            twe = 1'b1;
            priority if (tlb_policy_reg == tlbpt_pkg::POLICY_FIFO)
                twslot = tptr_reg;
            else if (tcount_reg != tlbpt_pkg::TLB_CT_W'(TE))
                twslot = tcount_reg[TLB_IX_W_LOC-1:0];
            else
                twslot = tinv_idx;
        end
        else if (cmd.tscan && tscan_done)
        begin
            twe = 1'b1;
        end
    end

    // TLB valid bits, fill pointer, fill count and stamp sweep control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= '0;
            tptr_reg   <= '0;
            tcount_reg <= '0;
            tidx_reg   <= '0;
        end
        else
        begin
            if (cmd.evict)
            begin
                for (int i = 0; i < TE; i++)
                begin
                    if (tframe_reg[i] == frame_reg)
                        tvalid_reg[i] <= 1'b0;
                end
            end
            if (twe)
                tvalid_reg[twslot] <= 1'b1;
            if (cmd.tfill && !tscan_needed)
            begin
                if (tlb_policy_reg == tlbpt_pkg::POLICY_FIFO)
                    tptr_reg <= tptr_reg + 1'b1;
                else if (tcount_reg != tlbpt_pkg::TLB_CT_W'(TE))
                    tcount_reg <= tcount_reg + 1'b1;
            end
            if (cmd.tfill && tscan_needed)
                tidx_reg <= tlbpt_pkg::TLB_CT_W'(1);
            else if (cmd.tscan && !tscan_done)
                tidx_reg <= tidx_reg + 1'b1;
        end
    end

    // TLB payload, restamp on hit, and the stamp minimum
    always_ff @(posedge clk)
    begin
        if (cmd.look && thit && tlb_policy_reg == tlbpt_pkg::POLICY_LRU)
            tstamp_reg[thit_idx] <= clock_reg;
        if (twe)
        begin
            tpage_reg[twslot]  <= page;
            tframe_reg[twslot] <= frame_reg;
            tstamp_reg[twslot] <= clock_reg;
        end
        if (cmd.tfill && tscan_needed)
        begin
            tbest_reg      <= tstamp_reg[0];
            tbest_slot_reg <= '0;
        end
        else if (cmd.tscan && !tscan_done
                 && tstamp_reg[tidx_reg[TLB_IX_W_LOC-1:0]] < tbest_reg)
        begin
            tbest_reg      <= tstamp_reg[tidx_reg[TLB_IX_W_LOC-1:0]];
            tbest_slot_reg <= tidx_reg[TLB_IX_W_LOC-1:0];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.finish)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            physical_address <= {frame_reg, offset};
            tlb_hit          <= hit_reg;
            page_fault       <= fault_reg;
            fill_frame       <= fault_reg ? frame_reg : '0;
            evicted          <= ev_reg;
        end
    end

    always_comb
    begin
        status.tlb_hit         = thit;
        status.page_valid      = pvalid_reg[page];
        status.frames_full     = (fiu_reg == tlbpt_pkg::FIU_W'(tlbpt_pkg::FRAME_COUNT));
        status.frame_policy    = frame_policy_reg;
        status.scan_done       = scan_done;
        status.tlb_scan_needed = tscan_needed;
        status.tscan_done      = tscan_done;
        status.out_free        = !out_valid || out_ready;
    end

    a_fiu_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fiu_reg <= tlbpt_pkg::FIU_W'(tlbpt_pkg::FRAME_COUNT))
        else $error("frame count overran");
    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && ev_reg |-> fault_reg)
        else $error("eviction without fault");
    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && hit_reg |-> !fault_reg)
        else $error("TLB hit and fault together");
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("result word lost");

endmodule

/* rtl/tlb_page_table_translator.sv */
// Top level of the TLB page-table translator.
// Depends on tlbpt_pkg, tlbpt_ctrl and tlbpt_datapath.
//
//  channel  handshake            payload
//  in       in_valid/in_ready    virtual_address
//  out      out_valid/out_ready  physical_address, tlb_hit, page_fault, fill_frame, evicted
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Steps after accept: a TLB hit goes LOOK, DONE; a table hit LOOK, TABLE, TFILL, DONE;
// a free-frame fault adds MAP before TFILL, a FIFO eviction EVICT_RD and EVICT before MAP;
// the LRU TLB sweep over 16 stamps adds TSCAN after TFILL. An LRU frame fault sweeps
// all 256 page-table stamps through the single read port in SCAN, before EVICT_RD.
// A waiting result stalls only the next completion; the next word is accepted while
// it waits. Reset clears every valid bit at once; no clearing pass is needed.
module tlb_page_table_translator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tlbpt_pkg::VA_W-1:0]    virtual_address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tlbpt_pkg::PA_W-1:0]    physical_address,
    output logic                          tlb_hit,
    output logic                          page_fault,
    output logic [tlbpt_pkg::FRAME_W-1:0] fill_frame,
    output logic                          evicted,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic                          cfg_data
);

    tlbpt_pkg::cmd_t    cmd;
    tlbpt_pkg::status_t status;

    // Always take configuration words
    assign cfg_ready = 1'b1;

    tlbpt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tlbpt_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .virtual_address  (virtual_address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .fill_frame       (fill_frame),
        .evicted          (evicted)
    );

endmodule

/* test/tlb_page_table_translator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the TLB page-table translator.
// Depends on tlbpt_pkg and tlb_page_table_translator; holds its own translation predictor.
module tlb_page_table_translator_tb;

    localparam int MAX_CYCLES = 4000000;

    typedef struct packed {
        logic [tlbpt_pkg::PA_W-1:0]    pa;
        logic                          hit;
        logic                          fault;
        logic [tlbpt_pkg::FRAME_W-1:0] fill;
        logic                          ev;
    } xlat_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [tlbpt_pkg::VA_W-1:0]    virtual_address;
    logic                          out_valid;
    logic                          out_ready;
    logic [tlbpt_pkg::PA_W-1:0]    physical_address;
    logic                          tlb_hit;
    logic                          page_fault;
    logic [tlbpt_pkg::FRAME_W-1:0] fill_frame;
    logic                          evicted;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic                          cfg_index;
    logic                          cfg_data;

    // Predictor state
    logic                           tlb_pol;
    logic                           frame_pol;
    logic                           pv [tlbpt_pkg::PAGE_COUNT];
    logic [tlbpt_pkg::FRAME_W-1:0]  pf [tlbpt_pkg::PAGE_COUNT];
    logic [31:0]                    pstamp [tlbpt_pkg::PAGE_COUNT];
    int unsigned                    used_frames;
    logic [tlbpt_pkg::FRAME_W-1:0]  rr_frame;
    logic [31:0]                    now_stamp;
    logic                           tv [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::PAGE_W-1:0]   tpage [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::FRAME_W-1:0]  tframe [tlbpt_pkg::TLB_ENTRIES];
    logic [31:0]                    tstamp [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::TLB_IX_W-1:0] tptr;
    int unsigned                    tcount;

    xlat_t       pending_xlat[$];
    int          mismatches;
    int          results_seen;
    int          hits_seen;
    int          faults_seen;
    int          evicts_seen;
    int          cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    tlb_page_table_translator i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .virtual_address  (virtual_address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .fill_frame       (fill_frame),
        .evicted          (evicted),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Clear the predictor as reset clears the block
    function automatic void clear_translator();
        tlb_pol = tlbpt_pkg::POLICY_FIFO;
        frame_pol = tlbpt_pkg::POLICY_FIFO;
        for (int i = 0; i < tlbpt_pkg::PAGE_COUNT; i++)
        begin
            pv[i] = 1'b0;
            pf[i] = '0;
            pstamp[i] = '0;
        end
        for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
        begin
            tv[i] = 1'b0;
            tpage[i] = '0;
            tframe[i] = '0;
            tstamp[i] = '0;
        end
        used_frames = 0;
        rr_frame = '0;
        now_stamp = '0;
        tptr = '0;
        tcount = 0;
    endfunction

    // Install a page mapping in the TLB under the current policy
    function automatic void refill_tlb(logic [tlbpt_pkg::PAGE_W-1:0] page,
                                       logic [tlbpt_pkg::FRAME_W-1:0] frame);
        int  slot;
        logic found;
        logic [31:0] oldest;
        slot = 0;
        if (tlb_pol == tlbpt_pkg::POLICY_FIFO)
        begin
            slot = tptr;
            tptr = tptr + 1'b1;
        end
        else if (tcount < tlbpt_pkg::TLB_ENTRIES)
        begin
            slot = tcount;
            tcount++;
        end
        else
        begin
            found = 1'b0;
            for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
            begin
                if (!found && !tv[i])
                begin
                    slot = i;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                oldest = tstamp[0];
                for (int i = 1; i < tlbpt_pkg::TLB_ENTRIES; i++)
                begin
                    if (tstamp[i] < oldest)
                    begin
                        oldest = tstamp[i];
                        slot = i;
                    end
                end
            end
        end
        tv[slot] = 1'b1;
        tpage[slot] = page;
        tframe[slot] = frame;
        tstamp[slot] = now_stamp;
    endfunction

    // Translate one address and advance the predictor state
    function automatic xlat_t translate(logic [tlbpt_pkg::VA_W-1:0] va);
        xlat_t r;
        logic [tlbpt_pkg::PAGE_W-1:0] page;
        logic [tlbpt_pkg::FRAME_W-1:0] frame;
        logic found;
        logic [31:0] oldest;
        page = va[tlbpt_pkg::VA_W-1:tlbpt_pkg::OFF_W];
        frame = '0;
        r = '0;
        for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
        begin
            if (!r.hit && tv[i] && tpage[i] == page)
            begin
                r.hit = 1'b1;
                frame = tframe[i];
                if (tlb_pol == tlbpt_pkg::POLICY_LRU)
                    tstamp[i] = now_stamp;
            end
        end
        if (!r.hit)
        begin
            if (pv[page])
                frame = pf[page];
            else
            begin
                r.fault = 1'b1;
                if (used_frames < tlbpt_pkg::FRAME_COUNT)
                begin
                    frame = used_frames[tlbpt_pkg::FRAME_W-1:0];
                    used_frames++;
                end
                else
                begin
                    if (frame_pol == tlbpt_pkg::POLICY_FIFO)
                    begin
                        frame = rr_frame;
                        rr_frame = rr_frame + 1'b1;
                    end
                    else
                    begin
                        found = 1'b0;
                        oldest = '0;
                        for (int i = 0; i < tlbpt_pkg::PAGE_COUNT; i++)
                        begin
                            if (pv[i] && (!found || pstamp[i] < oldest))
                            begin
                                oldest = pstamp[i];
                                frame = pf[i];
                                found = 1'b1;
                            end
                        end
                    end
                    // Drop every mapping of the victim frame
                    for (int i = 0; i < tlbpt_pkg::PAGE_COUNT; i++)
                        if (pv[i] && pf[i] == frame)
                            pv[i] = 1'b0;
                    for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
                        if (tv[i] && tframe[i] == frame)
                            tv[i] = 1'b0;
                    r.ev = 1'b1;
                end
                pv[page] = 1'b1;
                pf[page] = frame;
                r.fill = frame;
            end
            refill_tlb(page, frame);
        end
        pstamp[page] = now_stamp;
        now_stamp = now_stamp + 1;
        r.pa = {frame, va[tlbpt_pkg::OFF_W-1:0]};
        return r;
    endfunction

    // Send one address word and queue its expected translation
    task automatic send_address(logic [tlbpt_pkg::VA_W-1:0] va);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        virtual_address <= va;
        pending_xlat.push_back(translate(va));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Wait until every translation has arrived, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_xlat.size() != 0)
            @(posedge clk);
        repeat (300)
            @(posedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_policy(logic idx, logic val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == tlbpt_pkg::CFG_TLB_POLICY)
            tlb_pol = val;
        else
            frame_pol = val;
    endtask

    // Randomly stall the result side
    always @(posedge clk)
        out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        xlat_t want;
        xlat_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = {physical_address, tlb_hit, page_fault, fill_frame, evicted};
            results_seen++;
            if (pending_xlat.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", got);
            end
            else
            begin
                want = pending_xlat.pop_front();
                hits_seen += want.hit;
                faults_seen += want.fault;
                evicts_seen += want.ev;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: pa %h/%h hit %b/%b fault %b/%b fill %h/%h ev %b/%b",
                                 want.pa, got.pa, want.hit, got.hit, want.fault, got.fault,
                                 want.fill, got.fill, want.ev, got.ev);
                end
            end
        end
    end

    // End the run on a hang
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("ERROR: timeout with %0d results outstanding", pending_xlat.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Address extremes, offsets and every page hit path
    task automatic test_directed();
        send_address(16'h0000);
        send_address(16'h00FF);
        send_address(16'hFFFF);
        send_address(16'hFF00);
        send_address(16'h5AA5);
        send_address(16'hA55A);
        send_address(16'h0080);
        for (int i = 0; i < 17; i++)
            send_address({i[7:0], 8'h3C});
        send_address(16'h0001);
    endtask

    // Fill all frames, then fault past them to force evictions
    task automatic test_eviction(int count);
        for (int i = 0; i < count; i++)
            send_address({8'(($urandom_range(3) == 0) ? i : $urandom_range(255)), 8'($urandom)});
    endtask

    // Mix of a small hot set (TLB and table hits) and random pages
    task automatic test_random(int count);
        logic [7:0] base;
        base = $urandom;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(2) != 0)
                send_address({8'(base + $urandom_range(23)), 8'($urandom)});
            else
                send_address(16'($urandom));
            if ($urandom_range(63) == 0)
                base = $urandom;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        virtual_address = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = tlbpt_pkg::CFG_TLB_POLICY;
        cfg_data = tlbpt_pkg::POLICY_FIFO;
        mismatches = 0;
        results_seen = 0;
        hits_seen = 0;
        faults_seen = 0;
        evicts_seen = 0;
        cycles = 0;
        send_idle_pct = 27;
        recv_idle_pct = 86;
        clear_translator();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_eviction(300);
        test_random(250);
        write_policy(tlbpt_pkg::CFG_TLB_POLICY, tlbpt_pkg::POLICY_LRU);
        write_policy(tlbpt_pkg::CFG_FRAME_POLICY, tlbpt_pkg::POLICY_LRU);
        send_idle_pct = 86;
        recv_idle_pct = 27;
        test_random(350);
        test_eviction(150);
        write_policy(tlbpt_pkg::CFG_TLB_POLICY, tlbpt_pkg::POLICY_FIFO);
        test_random(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_policy(tlbpt_pkg::CFG_FRAME_POLICY, tlbpt_pkg::POLICY_FIFO);
        write_policy(tlbpt_pkg::CFG_TLB_POLICY, tlbpt_pkg::POLICY_LRU);
        test_random(300);
        write_policy(tlbpt_pkg::CFG_FRAME_POLICY, tlbpt_pkg::POLICY_LRU);
        test_random(200);
        drain();

        $display("Covered %0d translations: %0d TLB hits, %0d faults, %0d evictions",
                 results_seen, hits_seen, faults_seen, evicts_seen);
        $display("Both TLB and frame policies exercised under FIFO and LRU with stalls");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* tlb_page_table_translator.f */
rtl/tlbpt_pkg.sv
rtl/tlbpt_ctrl.sv
rtl/tlbpt_datapath.sv
rtl/tlb_page_table_translator.sv
test/tlb_page_table_translator_tb.sv
